[src/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types and constants of the 64-bit binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int unsigned MAX_DIGITS_DEF = 20;
	localparam int unsigned VALUE_W        = 64;
	localparam int unsigned CAP_W          = 6;
	localparam int unsigned CHAR_W         = 7;
	localparam int unsigned POS_W          = 5;
	localparam int unsigned LEN_W          = 5;
	localparam int unsigned BCD_W          = 4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [BCD_W-1:0]  BCD_FIVE = 4'd5;
	localparam logic [BCD_W-1:0]  BCD_ADJ  = 4'd3;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_CLEAR = 2'd1,
		CELL_CONV  = 2'd2,
		CELL_SHIFT = 2'd3
	} cell_op_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_NORM = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

endpackage

[src/i2a_cell.sv]
// ----------------------------------------------------------------------------
// i2a_cell
// One decimal digit of the shift-and-add-3 chain; also shifts whole digits.
// ----------------------------------------------------------------------------
module i2a_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2a_pkg::cell_op_t             op,
	input  logic                          carry_in,
	input  logic [i2a_pkg::BCD_W-1:0]     digit_in,
	output logic                          carry_out,
	output logic [i2a_pkg::BCD_W-1:0]     digit
);

	logic [i2a_pkg::BCD_W-1:0] digit_q;
	logic [i2a_pkg::BCD_W-1:0] adj;

	assign adj       = (digit_q >= i2a_pkg::BCD_FIVE) ? digit_q + i2a_pkg::BCD_ADJ : digit_q;
	assign carry_out = adj[i2a_pkg::BCD_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else begin
			unique case (op)
				i2a_pkg::CELL_HOLD:  digit_q <= digit_q;
				i2a_pkg::CELL_CLEAR: digit_q <= '0;
				i2a_pkg::CELL_CONV:  digit_q <= {adj[i2a_pkg::BCD_W-2:0], carry_in};
				i2a_pkg::CELL_SHIFT: digit_q <= digit_in;
				default:             digit_q <= digit_q;
			endcase
		end
	end

endmodule

[src/i2a_digit_chain.sv]
// ----------------------------------------------------------------------------
// i2a_digit_chain
// Row of digit cells, least significant digit at index 0.
// ----------------------------------------------------------------------------
module i2a_digit_chain #(
	parameter int unsigned MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2a_pkg::cell_op_t             op,
	input  logic                          bit_in,
	output logic [i2a_pkg::BCD_W-1:0]     top_digit
);

	logic [MAX_DIGITS:0]               carry;
	logic [i2a_pkg::BCD_W-1:0]         digit [MAX_DIGITS];
	logic [i2a_pkg::BCD_W-1:0]         digit_in [MAX_DIGITS];

	assign carry[0] = bit_in;

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign digit_in[i] = '0;
		end else begin : g_rest
			assign digit_in[i] = digit[i-1];
		end

		i2a_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.carry_in  (carry[i]),
			.digit_in  (digit_in[i]),
			.carry_out (carry[i+1]),
			.digit     (digit[i])
		);
	end

	assign top_digit = digit[MAX_DIGITS-1];

endmodule

[src/int64_to_decimal_ascii.sv]
// Steps: accept the word, shift-and-add-3 of each bit through the digit chain,
// strip up to MAX_DIGITS-1 leading zeros, then check the length against capacity.
// Then one character beat per cycle while m_tready is high, or a single failure beat.
// A new word is taken only after the last beat of the previous one is taken;
// the conversion is a 64-bit serial pass through the chain. Async reset
// returns the control to idle.
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// 64-bit word to decimal ASCII text, one character per output beat.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii #(
	parameter int unsigned MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // value[63:0], capacity[69:64], zero pad
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // character[6:0], position[11:7], length[16:12], zero pad
	output logic        m_tuser,   // failed
	output logic        m_tlast
);

	localparam int unsigned NDIG_W = $clog2(MAX_DIGITS + 1);
	localparam int unsigned CNT_W  = $clog2(i2a_pkg::VALUE_W);
	localparam int unsigned TOT_W  = NDIG_W + 1;

	i2a_pkg::state_t               state_q;
	logic [i2a_pkg::VALUE_W-1:0]   mag_q;
	logic [CNT_W-1:0]              bit_cnt_q;
	logic [NDIG_W-1:0]             ndig_q;
	logic                          neg_q;
	logic [i2a_pkg::CAP_W-1:0]     cap_q;
	logic [TOT_W-1:0]              len_q;
	logic                          fail_q;
	logic [i2a_pkg::POS_W-1:0]     pos_q;

	i2a_pkg::cell_op_t             op;
	logic [i2a_pkg::BCD_W-1:0]     top_digit;
	logic [i2a_pkg::VALUE_W-1:0]   in_value;
	logic                          in_neg;
	logic                          s_beat;
	logic                          m_beat;
	logic                          norm_step;
	logic                          minus_beat;
	logic                          last_beat;
	logic [TOT_W-1:0]              total;
	logic [i2a_pkg::CHAR_W-1:0]    character;

	assign in_value  = s_tdata[i2a_pkg::VALUE_W-1:0];
	assign in_neg    = s_tuser & in_value[i2a_pkg::VALUE_W-1];
	assign s_tready  = (state_q == i2a_pkg::ST_IDLE);
	assign s_beat    = s_tvalid & s_tready;
	assign m_tvalid  = (state_q == i2a_pkg::ST_EMIT);
	assign m_beat    = m_tvalid & m_tready;

	assign norm_step  = (state_q == i2a_pkg::ST_NORM) && (top_digit == '0) && (ndig_q > 1);
	assign total      = TOT_W'(ndig_q) + TOT_W'(neg_q);
	assign minus_beat = neg_q && (pos_q == '0);
	assign last_beat  = fail_q || (TOT_W'(pos_q) + TOT_W'(1) == len_q);

	always_comb begin
		op = i2a_pkg::CELL_HOLD;
		priority if (s_beat) begin
			op = i2a_pkg::CELL_CLEAR;
		end else if (state_q == i2a_pkg::ST_CONV) begin
			op = i2a_pkg::CELL_CONV;
		end else if (norm_step) begin
			op = i2a_pkg::CELL_SHIFT;
		end else if (m_beat && !fail_q && !minus_beat) begin
			op = i2a_pkg::CELL_SHIFT;
		end
	end

	i2a_digit_chain #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.bit_in    (mag_q[i2a_pkg::VALUE_W-1]),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= i2a_pkg::ST_IDLE;
			bit_cnt_q <= '0;
			ndig_q    <= '0;
			pos_q     <= '0;
			fail_q    <= 1'b0;
			len_q     <= '0;
		end else begin
			unique case (state_q)
				i2a_pkg::ST_IDLE: begin
					if (s_beat) begin
						bit_cnt_q <= '0;
						state_q   <= i2a_pkg::ST_CONV;
					end
				end
				i2a_pkg::ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + CNT_W'(1);
					if (bit_cnt_q == CNT_W'(i2a_pkg::VALUE_W - 1)) begin
						ndig_q  <= NDIG_W'(MAX_DIGITS);
						state_q <= i2a_pkg::ST_NORM;
					end
				end
				i2a_pkg::ST_NORM: begin
					if (norm_step) begin
						ndig_q <= ndig_q - NDIG_W'(1);
					end else begin
						len_q   <= total;
						fail_q  <= total > TOT_W'(cap_q);
						pos_q   <= '0;
						state_q <= i2a_pkg::ST_EMIT;
					end
				end
				i2a_pkg::ST_EMIT: begin
					if (m_beat) begin
						pos_q <= pos_q + i2a_pkg::POS_W'(1);
						if (last_beat) begin
							state_q <= i2a_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= i2a_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			mag_q <= in_neg ? (~in_value + i2a_pkg::VALUE_W'(1)) : in_value;
			neg_q <= in_neg;
			cap_q <= s_tdata[i2a_pkg::VALUE_W +: i2a_pkg::CAP_W];
		end else if (state_q == i2a_pkg::ST_CONV) begin
			mag_q <= {mag_q[i2a_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	always_comb begin
		priority if (fail_q) begin
			character = '0;
		end else if (minus_beat) begin
			character = i2a_pkg::CH_MINUS;
		end else begin
			character = i2a_pkg::CH_ZERO + i2a_pkg::CHAR_W'(top_digit);
		end
	end

	assign m_tdata = {7'd0,
	                  fail_q ? '0 : i2a_pkg::LEN_W'(len_q),
	                  fail_q ? '0 : pos_q,
	                  character};
	assign m_tuser = fail_q;
	assign m_tlast = last_beat;

endmodule
